>>> hw/rtl/mwcrg_pkg.sv
// Shared types, constants and the recurrence coefficient table for the
// multiply-with-carry random generator. No dependencies.
`default_nettype none

package mwcrg_pkg;

    localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [31:0] SEED_MUL    = 32'd29943829;
    localparam logic [31:0] EMPTY_CODE  = 32'h8000_0000;
    localparam logic [4:0]  WARMUP      = 5'd19;
    // Seed steps 0..3 fill the history words and the last one fills the carry.
    localparam logic [2:0]  SEED_CARRY  = 3'd4;

    typedef enum logic [1:0] {
        STATUS_GEN    = 2'd0,
        STATUS_SINGLE = 2'd1,
        STATUS_EMPTY  = 2'd2
    } status_t;

    // A classified request. For generated items value is the low bound;
    // for the special cases it is already the final ranged value.
    typedef struct packed {
        logic [32:0] interval;
        logic [31:0] value;
        status_t     status;
    } req_t;

    typedef enum logic [2:0] {
        ST_SEED,
        ST_SEED_WR,
        ST_ADV,
        ST_ADV_END,
        ST_IDLE,
        ST_SCALE,
        ST_OUT
    } state_t;

    // Coefficient for history word index term.
    function automatic logic [31:0] coef(input logic [1:0] term);
        logic [31:0] c;
        case (term)
            2'd0:    c = 32'd5115;
            2'd1:    c = 32'd1776;
            2'd2:    c = 32'd1492;
            default: c = 32'd2111111111;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/mwcrg_front.sv
// Request front end: checks the requested range and forms a queue entry.
// Depends on mwcrg_pkg.
`default_nettype none

module mwcrg_front (
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [63:0]       s_tdata,
    input  wire logic              q_full,
    output logic                   q_push,
    output mwcrg_pkg::req_t        q_entry
);

    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
    logic        [32:0] span;

    assign range_low  = s_tdata[31:0];
    assign range_high = s_tdata[63:32];

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    // The difference is exact in 33 bits and lies in 1 .. 2^32 once incremented.
    assign span = {range_high[31], range_high} - {range_low[31], range_low} + 33'd1;

    always_comb
    begin
        q_entry.interval = span;
        q_entry.value    = range_low;
        q_entry.status   = mwcrg_pkg::STATUS_GEN;
        if (range_high == range_low)
        begin
            q_entry.status = mwcrg_pkg::STATUS_SINGLE;
        end
        else if (range_high < range_low)
        begin
            q_entry.value  = mwcrg_pkg::EMPTY_CODE;
            q_entry.status = mwcrg_pkg::STATUS_EMPTY;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/mwcrg_queue.sv
// Short request queue between the front end and the generator engine.
// Depends on mwcrg_pkg for the entry type.
`default_nettype none

module mwcrg_queue #(
    parameter int unsigned DEPTH = mwcrg_pkg::QUEUE_DEPTH_DEFAULT  // 2 .. 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire mwcrg_pkg::req_t push_data,
    output logic                 full,
    input  wire logic            pop,
    output logic                 pop_valid,
    output mwcrg_pkg::req_t      pop_data
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    mwcrg_pkg::req_t   entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("request pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> pop_valid)
        else $error("request popped from an empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

>>> hw/rtl/mwcrg_back.sv
// Generator engine: seeding, warm-up, the multiply-with-carry recurrence and
// range scaling on one shared 32x32 multiplier, plus the result register.
// Depends on mwcrg_pkg.
`default_nettype none

module mwcrg_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_wr_en,
    input  wire logic [31:0]     cfg_wr_data,
    input  wire logic            q_valid,
    input  wire mwcrg_pkg::req_t q_data,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic [63:0]          m_tdata,
    output logic [1:0]           m_tuser
);

    mwcrg_pkg::state_t  state_reg;
    mwcrg_pkg::state_t  state_next;
    logic [31:0]        seed_reg;
    logic [31:0]        seed_next;
    logic [2:0]         seed_idx_reg;
    logic [2:0]         seed_idx_next;
    logic [4:0]         warm_cnt_reg;
    logic [4:0]         warm_cnt_next;
    logic [1:0]         term_reg;
    logic [1:0]         term_next;
    logic [63:0]        acc_reg;
    logic [63:0]        acc_next;
    logic [63:0]        prod_reg;
    logic [31:0]        hist_reg [4];
    logic [31:0]        hist_next [4];
    logic [31:0]        carry_reg;
    logic [31:0]        carry_next;
    mwcrg_pkg::req_t    job_reg;
    mwcrg_pkg::req_t    job_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [31:0]        out_raw_reg;
    logic [31:0]        out_raw_next;
    logic [31:0]        out_value_reg;
    logic [31:0]        out_value_next;
    mwcrg_pkg::status_t out_status_reg;
    mwcrg_pkg::status_t out_status_next;

    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [63:0]        sum;
    logic [31:0]        seed_step;
    logic [31:0]        scaled;
    logic               slot_free;

    assign slot_free = !out_valid_reg || m_tready;
    assign q_pop     = (state_reg == mwcrg_pkg::ST_IDLE) && q_valid && slot_free && !cfg_wr_en;
    assign sum       = acc_reg + prod_reg;
    assign seed_step = prod_reg[31:0] - 32'd1;
    // An interval of 2^32 scales the word by one.
    assign scaled    = job_reg.interval[32] ? hist_reg[0] : prod_reg[63:32];

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_value_reg, out_raw_reg};
    assign m_tuser  = out_status_reg;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            mwcrg_pkg::ST_SEED:
            begin
                mul_a = seed_reg;
                mul_b = mwcrg_pkg::SEED_MUL;
            end
            mwcrg_pkg::ST_ADV:
            begin
                mul_a = hist_reg[term_reg];
                mul_b = mwcrg_pkg::coef(term_reg);
            end
            mwcrg_pkg::ST_SCALE:
            begin
                mul_a = hist_reg[0];
                mul_b = job_reg.interval[31:0];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        if (cfg_wr_en)
        begin
            state_next = mwcrg_pkg::ST_SEED;
        end
        else
        begin
            unique case (state_reg)
                mwcrg_pkg::ST_SEED:
                    state_next = mwcrg_pkg::ST_SEED_WR;
                mwcrg_pkg::ST_SEED_WR:
                    state_next = (seed_idx_reg == mwcrg_pkg::SEED_CARRY) ?
                                 mwcrg_pkg::ST_ADV : mwcrg_pkg::ST_SEED;
                mwcrg_pkg::ST_ADV:
                    state_next = (term_reg == 2'd3) ? mwcrg_pkg::ST_ADV_END : mwcrg_pkg::ST_ADV;
                mwcrg_pkg::ST_ADV_END:
                begin
                    if (warm_cnt_reg == mwcrg_pkg::WARMUP)
                    begin
                        state_next = mwcrg_pkg::ST_SCALE;
                    end
                    else if (warm_cnt_reg + 5'd1 == mwcrg_pkg::WARMUP)
                    begin
                        state_next = mwcrg_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = mwcrg_pkg::ST_ADV;
                    end
                end
                mwcrg_pkg::ST_IDLE:
                    if (q_pop && q_data.status == mwcrg_pkg::STATUS_GEN)
                    begin
                        state_next = mwcrg_pkg::ST_ADV;
                    end
                mwcrg_pkg::ST_SCALE:
                    state_next = mwcrg_pkg::ST_OUT;
                mwcrg_pkg::ST_OUT:
                    state_next = mwcrg_pkg::ST_IDLE;
                default:
                    state_next = mwcrg_pkg::ST_IDLE;
            endcase
        end
    end

    // Datapath and result register updates.
    always_comb
    begin
        seed_next       = seed_reg;
        seed_idx_next   = seed_idx_reg;
        warm_cnt_next   = warm_cnt_reg;
        term_next       = term_reg;
        acc_next        = acc_reg;
        hist_next       = hist_reg;
        carry_next      = carry_reg;
        job_next        = job_reg;
        out_raw_next    = out_raw_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_valid_next  = m_tready ? 1'b0 : out_valid_reg;

        if (cfg_wr_en)
        begin
            seed_next     = cfg_wr_data;
            seed_idx_next = '0;
            warm_cnt_next = '0;
        end
        else
        begin
            unique case (state_reg)
                mwcrg_pkg::ST_SEED:
                begin
                end
                mwcrg_pkg::ST_SEED_WR:
                begin
                    seed_next = seed_step;
                    if (seed_idx_reg == mwcrg_pkg::SEED_CARRY)
                    begin
                        carry_next = seed_step;
                        term_next  = '0;
                    end
                    else
                    begin
                        hist_next[seed_idx_reg[1:0]] = seed_step;
                        seed_idx_next = seed_idx_reg + 3'd1;
                    end
                end
                mwcrg_pkg::ST_ADV:
                begin
                    // The registered product of the previous term is folded in at the next term.
                    acc_next  = (term_reg == 2'd0) ? {32'd0, carry_reg} : sum;
                    term_next = term_reg + 2'd1;
                end
                mwcrg_pkg::ST_ADV_END:
                begin
                    hist_next[3] = hist_reg[2];
                    hist_next[2] = hist_reg[1];
                    hist_next[1] = hist_reg[0];
                    hist_next[0] = sum[31:0];
                    carry_next   = sum[63:32];
                    term_next    = '0;
                    if (warm_cnt_reg != mwcrg_pkg::WARMUP)
                    begin
                        warm_cnt_next = warm_cnt_reg + 5'd1;
                    end
                end
                mwcrg_pkg::ST_IDLE:
                begin
                    if (q_pop)
                    begin
                        job_next  = q_data;
                        term_next = '0;
                        if (q_data.status != mwcrg_pkg::STATUS_GEN)
                        begin
                            out_valid_next  = 1'b1;
                            out_raw_next    = '0;
                            out_value_next  = q_data.value;
                            out_status_next = q_data.status;
                        end
                    end
                end
                mwcrg_pkg::ST_SCALE:
                begin
                end
                mwcrg_pkg::ST_OUT:
                begin
                    out_valid_next  = 1'b1;
                    out_raw_next    = hist_reg[0];
                    out_value_next  = scaled + job_reg.value;
                    out_status_next = mwcrg_pkg::STATUS_GEN;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mwcrg_pkg::ST_SEED;
            seed_reg      <= '0;
            seed_idx_reg  <= '0;
            warm_cnt_reg  <= '0;
            term_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seed_reg      <= seed_next;
            seed_idx_reg  <= seed_idx_next;
            warm_cnt_reg  <= warm_cnt_next;
            term_reg      <= term_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg       <= {32'd0, mul_a} * {32'd0, mul_b};
        acc_reg        <= acc_next;
        hist_reg       <= hist_next;
        carry_reg      <= carry_next;
        job_reg        <= job_next;
        out_raw_reg    <= out_raw_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    a_idle_warm: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mwcrg_pkg::ST_IDLE) |-> (warm_cnt_reg == mwcrg_pkg::WARMUP))
        else $error("engine idle before warm-up finished");

    a_out_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mwcrg_pkg::ST_OUT) |-> slot_free)
        else $error("generated result would overwrite a pending result");

    a_request_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mwcrg_pkg::ST_ADV_END && warm_cnt_reg == mwcrg_pkg::WARMUP
         && !cfg_wr_en) |=> (state_reg == mwcrg_pkg::ST_SCALE))
        else $error("request advance did not proceed to scaling");

endmodule

`default_nettype wire

>>> hw/rtl/multiply_with_carry_random_generator.sv
// Multiply-with-carry random generator with four history words and a carry.
// A request whose range holds more than one value takes, in the engine,
// four steps for the recurrence terms, one to fold the sum, and two
// for range scaling, all on one shared 32x32 multiplier, plus the pop step.
// A single-value or empty range is answered at the pop without advancing.
// After reset, and after every seed write, seeding and warm-up occupy the
// engine for 5 seed steps and 19 advances of the recurrence; requests are
// queued meanwhile and answered in order afterwards.
// Depends on mwcrg_pkg, mwcrg_front, mwcrg_queue and mwcrg_back.
`default_nettype none

module multiply_with_carry_random_generator #(
    parameter int unsigned QUEUE_DEPTH = mwcrg_pkg::QUEUE_DEPTH_DEFAULT  // 2 .. 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,   // seed
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,       // [31:0] range_low, [63:32] range_high
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,       // [31:0] raw_word, [63:32] ranged_value
    output logic [1:0]       m_tuser        // [1:0] status
);

    logic            q_full;
    logic            q_push;
    logic            q_pop;
    logic            q_valid;
    mwcrg_pkg::req_t q_entry;
    mwcrg_pkg::req_t q_head;

    mwcrg_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    mwcrg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_entry),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_head)
    );

    mwcrg_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (q_valid),
        .q_data      (q_head),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

`default_nettype wire
